// ----- hw/rtl/bqss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqss_pkg
// Shared field widths, codes and types for the bucket queue set scan unit.
// ----------------------------------------------------------------------------
package bqss_pkg;

    localparam int SET_SIZE    = 8;
    localparam int MODE_W      = 1;
    localparam int BUCKET_W    = 6;
    localparam int PAYLOAD_W   = 64;
    localparam int STATUS_W    = 3;
    localparam int SET_COUNT_W = 4;

    localparam logic [SET_COUNT_W-1:0] SET_COUNT_RESET = 4'd8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [MODE_W-1:0] MODE_ENQ = 1'b0;
    localparam logic [MODE_W-1:0] MODE_DEQ = 1'b1;

    localparam logic BKT_DRAINED = 1'b0;
    localparam logic BKT_HOLDING = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ENQUEUED = 3'd0,
        ST_FULL     = 3'd1,
        ST_BAD      = 3'd2,
        ST_DEQUEUED = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_ENQ = 2'd0,
        OP_BAD = 2'd1,
        OP_DEQ = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE   = 2'd0,
        BK_LOOKUP = 2'd1,
        BK_UPDATE = 2'd2,
        BK_FETCH  = 2'd3
    } bk_state_t;

    typedef struct packed {
        op_t                  op;
        logic [BUCKET_W-1:0]  bucket;
        logic [PAYLOAD_W-1:0] payload;
    } cmd_t;

endpackage

// ----- hw/rtl/bqss_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqss_front
// Request intake: holds the set count register, checks the bucket index and
// classifies each request word before it enters the command queue.
// ----------------------------------------------------------------------------
module bqss_front #(
    parameter int NUM_BUCKETS = 64
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   cfg_wr_en,
    input  logic [bqss_pkg::SET_COUNT_W-1:0]                       cfg_wr_data,
    input  logic                                                   req_valid,
    output logic                                                   req_stall,
    input  logic [bqss_pkg::MODE_W-1:0]                            mode,
    input  logic [bqss_pkg::BUCKET_W-1:0]                          bucket,
    input  logic [bqss_pkg::PAYLOAD_W-1:0]                         payload,
    output logic                                                   push,
    output bqss_pkg::cmd_t                                         push_cmd,
    input  logic                                                   q_full,
    output logic [$clog2(NUM_BUCKETS/bqss_pkg::SET_SIZE+1)-1:0]    nsets
);
    import bqss_pkg::*;

    localparam int MAX_SETS = NUM_BUCKETS / SET_SIZE;
    localparam int SETS_W   = $clog2(MAX_SETS + 1);
    localparam int LIMIT_W  = SETS_W + $clog2(SET_SIZE);
    localparam int CMP_W    = (LIMIT_W > BUCKET_W) ? LIMIT_W : BUCKET_W;

    logic [SET_COUNT_W-1:0] set_count_reg;
    logic [SET_COUNT_W-1:0] set_count_next;
    logic [LIMIT_W-1:0]     bucket_limit;
    logic                   bad_bucket;

    always_comb
    begin
        set_count_next = cfg_wr_en ? cfg_wr_data : set_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_count_reg <= SET_COUNT_RESET;
        end
        else
        begin
            set_count_reg <= set_count_next;
        end
    end

    // saturate the set count to the sets that exist; a count of zero gives one set
    always_comb
    begin
        if (set_count_reg == '0)
        begin
            nsets = SETS_W'(1);
        end
        else if (32'(set_count_reg) > MAX_SETS)
        begin
            nsets = SETS_W'(MAX_SETS);
        end
        else
        begin
            nsets = SETS_W'(set_count_reg);
        end
    end

    always_comb
    begin
        bucket_limit = LIMIT_W'(nsets) * LIMIT_W'(SET_SIZE);
        bad_bucket   = CMP_W'(bucket) >= CMP_W'(bucket_limit);

        push_cmd.bucket  = bucket;
        push_cmd.payload = payload;
        if (mode == MODE_DEQ)
        begin
            push_cmd.op = OP_DEQ;
        end
        else if (bad_bucket)
        begin
            push_cmd.op = OP_BAD;
        end
        else
        begin
            push_cmd.op = OP_ENQ;
        end
    end

    assign req_stall = q_full;
    assign push      = req_valid && !q_full;

endmodule

// ----- hw/rtl/bqss_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqss_queue
// Short command queue between the intake and the execution engine.
// ----------------------------------------------------------------------------
module bqss_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bqss_pkg::cmd_t push_cmd,
    output logic           q_full,
    input  logic           pop,
    output bqss_pkg::cmd_t pop_cmd,
    output logic           q_valid
);
    import bqss_pkg::*;

    cmd_t              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

    assign pop_cmd = q_mem[rd_ptr_reg];
    assign q_full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign q_valid = count_reg != '0;

endmodule

// ----- hw/rtl/bqss_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqss_back
// Execution engine: rotating set scan over the nonempty flags, pointer
// read-modify-write, word store access and the result register.
// ----------------------------------------------------------------------------
module bqss_back #(
    parameter int NUM_BUCKETS  = 64,
    parameter int BUCKET_DEPTH = 16,
    parameter int WORD_WIDTH   = 64
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic [$clog2(NUM_BUCKETS/bqss_pkg::SET_SIZE+1)-1:0] nsets,
    input  logic                                                q_valid,
    input  bqss_pkg::cmd_t                                      pop_cmd,
    output logic                                                pop,
    output logic                                                rsp_valid,
    input  logic                                                rsp_stall,
    output logic [bqss_pkg::STATUS_W-1:0]                       status,
    output logic [bqss_pkg::PAYLOAD_W-1:0]                      out_word,
    output logic [bqss_pkg::BUCKET_W-1:0]                       from_bucket
);
    import bqss_pkg::*;

    localparam int MAX_SETS    = NUM_BUCKETS / SET_SIZE;
    localparam int SETS_W      = $clog2(MAX_SETS + 1);
    localparam int SET_W       = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int BKT_W       = $clog2(NUM_BUCKETS);
    localparam int HEAD_W      = $clog2(BUCKET_DEPTH);
    localparam int FILL_W      = $clog2(BUCKET_DEPTH + 1);
    localparam int SUM_W       = HEAD_W + 1;
    localparam int STORE_DEPTH = NUM_BUCKETS * BUCKET_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int GROUPS      = (MAX_SETS + SET_SIZE - 1) / SET_SIZE;
    localparam int PAD_SETS    = GROUPS * SET_SIZE;
    localparam int GRP_W       = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int LANE_W      = $clog2(SET_SIZE);

    typedef struct packed {
        logic [HEAD_W-1:0] head;
        logic [FILL_W-1:0] fill;
    } ptr_t;

    // memories
    ptr_t                  ptr_mem  [NUM_BUCKETS];
    logic [WORD_WIDTH-1:0] word_mem [STORE_DEPTH];
    ptr_t                  ptr_rd_reg;
    logic [WORD_WIDTH-1:0] word_rd_reg;

    // control state
    bk_state_t             state_reg;
    bk_state_t             state_next;
    logic [SET_W-1:0]      start_reg;
    logic [SET_W-1:0]      start_next;
    logic [NUM_BUCKETS-1:0] flags_reg;
    logic [NUM_BUCKETS-1:0] flags_next;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;

    // current command
    op_t                   op_reg;
    op_t                   op_next;
    logic [BKT_W-1:0]      idx_reg;
    logic [BKT_W-1:0]      idx_next;
    logic [WORD_WIDTH-1:0] word_reg;
    logic [WORD_WIDTH-1:0] word_next;
    logic                  found_reg;
    logic                  found_next;
    logic [SET_W-1:0]      set_reg;
    logic [SET_W-1:0]      set_next;

    // result
    status_t               status_reg;
    status_t               status_next;
    logic [PAYLOAD_W-1:0]  out_word_reg;
    logic [PAYLOAD_W-1:0]  out_word_next;
    logic [BUCKET_W-1:0]   from_reg;
    logic [BUCKET_W-1:0]   from_next;
    logic                  rsp_load;

    // scan
    logic [PAD_SETS-1:0]   cand;
    logic [PAD_SETS-1:0]   upper;
    logic [PAD_SETS-1:0]   pick;
    logic [GROUPS-1:0]     grp_any;
    logic [LANE_W-1:0]     grp_first [GROUPS];
    logic [GRP_W-1:0]      grp_sel;
    logic [SET_W-1:0]      scan_set;
    logic [SET_SIZE-1:0]   set_flags;
    logic [LANE_W-1:0]     lane;
    logic                  scan_found;
    logic [BKT_W-1:0]      scan_idx;

    // pointer update
    logic                  cur_nonempty;
    logic [HEAD_W-1:0]     cur_head;
    logic [FILL_W-1:0]     cur_fill;
    logic                  bucket_full;
    logic [SUM_W-1:0]      slot_sum;
    logic [HEAD_W-1:0]     tail_slot;
    logic [HEAD_W-1:0]     head_inc;
    logic [HEAD_W-1:0]     slot_sel;
    logic [ADDR_W-1:0]     word_addr;
    logic                  ptr_we;
    ptr_t                  ptr_wdata;
    logic                  word_we;

    logic                  start_above;
    logic                  fold_due;
    logic                  out_free;
    logic                  launch;

    assign start_above = SETS_W'(start_reg) >= nsets;
    assign fold_due    = start_above && q_valid && (pop_cmd.op == OP_DEQ);
    assign out_free    = !rsp_valid_reg || !rsp_stall;
    assign launch      = !fold_due && q_valid && out_free;

    // sets in use with any flag up, and those at or after the start set
    always_comb
    begin
        cand  = '0;
        upper = '0;
        for (int s = 0; s < MAX_SETS; s++)
        begin
            cand[s]  = (|flags_reg[s*SET_SIZE +: SET_SIZE]) && (s < int'(nsets));
            upper[s] = cand[s] && (s >= int'(start_reg));
        end
        pick       = (|upper) ? upper : cand;
        scan_found = |cand;
    end

    // two-level first-set search
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_any[g]   = |pick[g*SET_SIZE +: SET_SIZE];
            grp_first[g] = '0;
            for (int j = SET_SIZE - 1; j >= 0; j--)
            begin
                if (pick[g*SET_SIZE + j])
                begin
                    grp_first[g] = LANE_W'(j);
                end
            end
        end
        grp_sel = '0;
        for (int g = GROUPS - 1; g >= 0; g--)
        begin
            if (grp_any[g])
            begin
                grp_sel = GRP_W'(g);
            end
        end
        scan_set = SET_W'(int'(grp_sel) * SET_SIZE + int'(grp_first[grp_sel]));
    end

    // lowest nonempty bucket of the chosen set
    always_comb
    begin
        set_flags = flags_reg[int'(scan_set)*SET_SIZE +: SET_SIZE];
        lane      = '0;
        for (int j = SET_SIZE - 1; j >= 0; j--)
        begin
            if (set_flags[j])
            begin
                lane = LANE_W'(j);
            end
        end
        scan_idx = BKT_W'(int'(scan_set) * SET_SIZE + int'(lane));
    end

    // drained buckets read as empty with head at slot zero
    always_comb
    begin
        cur_nonempty = flags_reg[idx_reg] == BKT_HOLDING;
        cur_head     = cur_nonempty ? ptr_rd_reg.head : '0;
        cur_fill     = cur_nonempty ? ptr_rd_reg.fill : '0;
        bucket_full  = cur_fill == FILL_W'(BUCKET_DEPTH);
        slot_sum     = SUM_W'(cur_head) + SUM_W'(cur_fill);
        if (slot_sum >= SUM_W'(BUCKET_DEPTH))
        begin
            tail_slot = HEAD_W'(slot_sum - SUM_W'(BUCKET_DEPTH));
        end
        else
        begin
            tail_slot = HEAD_W'(slot_sum);
        end
        if (cur_head == HEAD_W'(BUCKET_DEPTH - 1))
        begin
            head_inc = '0;
        end
        else
        begin
            head_inc = cur_head + HEAD_W'(1);
        end
        slot_sel  = (op_reg == OP_DEQ) ? cur_head : tail_slot;
        word_addr = ADDR_W'(idx_reg) * ADDR_W'(BUCKET_DEPTH) + ADDR_W'(slot_sel);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (launch)
                begin
                    state_next = BK_LOOKUP;
                end
            end
            BK_LOOKUP:
            begin
                state_next = BK_UPDATE;
            end
            BK_UPDATE:
            begin
                if (op_reg == OP_DEQ && found_reg)
                begin
                    state_next = BK_FETCH;
                end
                else
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_FETCH:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // datapath controls
    always_comb
    begin
        pop           = 1'b0;
        op_next       = op_reg;
        idx_next      = idx_reg;
        word_next     = word_reg;
        found_next    = found_reg;
        set_next      = set_reg;
        start_next    = start_reg;
        flags_next    = flags_reg;
        ptr_we        = 1'b0;
        ptr_wdata     = ptr_rd_reg;
        word_we       = 1'b0;
        rsp_load      = 1'b0;
        status_next   = status_reg;
        out_word_next = '0;
        from_next     = '0;

        case (state_reg)
            BK_IDLE:
            begin
                if (fold_due)
                begin
                    // fold the start set into the sets in use
                    start_next = start_reg - SET_W'(nsets);
                end
                else if (launch)
                begin
                    pop        = 1'b1;
                    op_next    = pop_cmd.op;
                    idx_next   = (pop_cmd.op == OP_DEQ) ? scan_idx : BKT_W'(pop_cmd.bucket);
                    word_next  = WORD_WIDTH'(pop_cmd.payload);
                    found_next = scan_found;
                    set_next   = scan_set;
                end
            end
            BK_UPDATE:
            begin
                case (op_reg)
                    OP_BAD:
                    begin
                        rsp_load    = 1'b1;
                        status_next = ST_BAD;
                    end
                    OP_ENQ:
                    begin
                        rsp_load = 1'b1;
                        if (bucket_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            status_next        = ST_ENQUEUED;
                            word_we            = 1'b1;
                            ptr_we             = 1'b1;
                            ptr_wdata.head     = cur_head;
                            ptr_wdata.fill     = cur_fill + FILL_W'(1);
                            flags_next[idx_reg] = BKT_HOLDING;
                        end
                    end
                    OP_DEQ:
                    begin
                        if (found_reg)
                        begin
                            ptr_we         = 1'b1;
                            ptr_wdata.head = head_inc;
                            ptr_wdata.fill = cur_fill - FILL_W'(1);
                            if (cur_fill == FILL_W'(1))
                            begin
                                flags_next[idx_reg] = BKT_DRAINED;
                            end
                            start_next = set_reg;
                        end
                        else
                        begin
                            rsp_load    = 1'b1;
                            status_next = ST_EMPTY;
                        end
                    end
                    default:
                    begin
                        rsp_load    = 1'b1;
                        status_next = ST_BAD;
                    end
                endcase
            end
            BK_FETCH:
            begin
                rsp_load      = 1'b1;
                status_next   = ST_DEQUEUED;
                out_word_next = PAYLOAD_W'(word_rd_reg);
                from_next     = BUCKET_W'(idx_reg);
            end
            default:
            begin
            end
        endcase

        rsp_valid_next = rsp_load || (rsp_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            start_reg     <= '0;
            flags_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            flags_reg     <= flags_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        idx_reg   <= idx_next;
        word_reg  <= word_next;
        found_reg <= found_next;
        set_reg   <= set_next;
        if (rsp_load)
        begin
            status_reg   <= status_next;
            out_word_reg <= out_word_next;
            from_reg     <= from_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ptr_we)
        begin
            ptr_mem[idx_reg] <= ptr_wdata;
        end
        ptr_rd_reg <= ptr_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (word_we)
        begin
            word_mem[word_addr] <= word_reg;
        end
        word_rd_reg <= word_mem[word_addr];
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign out_word    = out_word_reg;
    assign from_bucket = from_reg;

endmodule

// ----- hw/rtl/bucket_queue_set_scan_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucket_queue_set_scan_unit
// Bank of bounded FIFO buckets with a rotating scan over eight-bucket sets.
// ----------------------------------------------------------------------------
// Requests enter through a two-word command queue, so up to two requests are
// taken while the engine is busy or a result waits on the output. The engine
// runs one request at a time, stepping through a lookup and an update state
// and, for a dequeue that returns a word, a fetch state; the lookup waits on
// the registered read of the bucket pointer memory and the fetch on the
// registered read of the word store. After the set count is lowered to or
// below the stored scan start, the next dequeue first has the set count
// subtracted from the start repeatedly, folding it back into range, before
// the engine takes it; enqueues are not held up by this. Words in the store
// are not cleared at reset; no clearing pass is run.
// ----------------------------------------------------------------------------
module bucket_queue_set_scan_unit #(
    parameter int NUM_BUCKETS  = 64,
    parameter int BUCKET_DEPTH = 16,
    parameter int WORD_WIDTH   = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [bqss_pkg::SET_COUNT_W-1:0] cfg_wr_data,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic [bqss_pkg::MODE_W-1:0]      mode,
    input  logic [bqss_pkg::BUCKET_W-1:0]    bucket,
    input  logic [bqss_pkg::PAYLOAD_W-1:0]   payload,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic [bqss_pkg::STATUS_W-1:0]    status,
    output logic [bqss_pkg::PAYLOAD_W-1:0]   out_word,
    output logic [bqss_pkg::BUCKET_W-1:0]    from_bucket
);
    import bqss_pkg::*;

    localparam int MAX_SETS = NUM_BUCKETS / SET_SIZE;
    localparam int SETS_W   = $clog2(MAX_SETS + 1);

    logic              push;
    cmd_t              push_cmd;
    logic              q_full;
    logic              pop;
    cmd_t              pop_cmd;
    logic              q_valid;
    logic [SETS_W-1:0] nsets;

    bqss_front #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .mode        (mode),
        .bucket      (bucket),
        .payload     (payload),
        .push        (push),
        .push_cmd    (push_cmd),
        .q_full      (q_full),
        .nsets       (nsets)
    );

    bqss_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_valid  (q_valid)
    );

    bqss_back #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .BUCKET_DEPTH (BUCKET_DEPTH),
        .WORD_WIDTH   (WORD_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .nsets       (nsets),
        .q_valid     (q_valid),
        .pop_cmd     (pop_cmd),
        .pop         (pop),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .out_word    (out_word),
        .from_bucket (from_bucket)
    );

endmodule

// ----- verif/bucket_queue_set_scan_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucket_queue_set_scan_unit_tb
// Self-checking bench for the bucket queue set scan unit. Enqueue and dequeue
// words are driven through the request channel. A scoreboard keeps its own
// copy of the buckets, fill counts, nonempty flags, scan start and set count.
// It predicts one result per accepted request and compares every returned
// word field by field, in order. A directed opening covers the empty scan,
// both extreme buckets and words, the rotating start, an out-of-range start,
// a bad bucket and a full bucket. Randomised phases then run under a range of
// set counts with random idling on both channels.
// ----------------------------------------------------------------------------
module bucket_queue_set_scan_unit_tb;
    import bqss_pkg::*;

    localparam int NUM_BUCKETS  = 64;
    localparam int BUCKET_DEPTH = 16;
    localparam int WORD_WIDTH   = 64;
    localparam int MAX_SETS     = NUM_BUCKETS / SET_SIZE;
    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 7;
    localparam int NUM_PHASES   = 12;
    localparam int FIXED_PHASES = 10;
    localparam int PHASE_ITEMS  = 125;
    localparam int MAX_GAP      = 19;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 20;
    localparam int MAX_PRINTED  = 100;

    typedef struct {
        status_t              status;
        logic [PAYLOAD_W-1:0] word;
        logic [BUCKET_W-1:0]  src_bucket;
    } scan_result_t;

    class bucket_scoreboard;
        logic [PAYLOAD_W-1:0]   word_mem [NUM_BUCKETS][BUCKET_DEPTH];
        int unsigned            head [NUM_BUCKETS];
        int unsigned            fill [NUM_BUCKETS];
        logic                   flag [NUM_BUCKETS];
        int unsigned            start_set;
        logic [SET_COUNT_W-1:0] set_count;
        scan_result_t           expected_q [$];
        int                     errors;
        int                     requests;
        int                     n_enqueued;
        int                     n_full;
        int                     n_bad;
        int                     n_dequeued;
        int                     n_empty;

        function new();
            for (int i = 0; i < NUM_BUCKETS; i++)
            begin
                head[i] = 0;
                fill[i] = 0;
                flag[i] = BKT_DRAINED;
            end
            start_set  = 0;
            set_count  = SET_COUNT_RESET;
            errors     = 0;
            requests   = 0;
            n_enqueued = 0;
            n_full     = 0;
            n_bad      = 0;
            n_dequeued = 0;
            n_empty    = 0;
        endfunction

        function void write_set_count(logic [SET_COUNT_W-1:0] value);
            set_count = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(logic [MODE_W-1:0] m, logic [BUCKET_W-1:0] b,
                                   logic [PAYLOAD_W-1:0] p);
            int unsigned  nsets;
            int unsigned  cur_set;
            int unsigned  idx;
            int unsigned  slot;
            bit           found;
            scan_result_t res;

            nsets = (set_count == 0) ? 1 : ((set_count > MAX_SETS) ? MAX_SETS : set_count);
            res.status     = ST_EMPTY;
            res.word       = '0;
            res.src_bucket = '0;
            requests++;
            if (m == MODE_ENQ)
            begin
                idx = b;
                if (idx >= nsets * SET_SIZE || idx >= NUM_BUCKETS)
                begin
                    res.status = ST_BAD;
                    n_bad++;
                end
                else if (fill[idx] >= BUCKET_DEPTH)
                begin
                    res.status = ST_FULL;
                    n_full++;
                end
                else
                begin
                    slot = (head[idx] + fill[idx]) % BUCKET_DEPTH;
                    word_mem[idx][slot] = p;
                    fill[idx]++;
                    flag[idx] = BKT_HOLDING;
                    res.status = ST_ENQUEUED;
                    n_enqueued++;
                end
            end
            else
            begin
                found = 1'b0;
                for (int unsigned i = 0; i < nsets && !found; i++)
                begin
                    cur_set = (start_set % nsets + i) % nsets;
                    for (int unsigned j = 0; j < SET_SIZE && !found; j++)
                    begin
                        idx = cur_set * SET_SIZE + j;
                        if (flag[idx] == BKT_HOLDING && fill[idx] != 0)
                        begin
                            res.status     = ST_DEQUEUED;
                            res.word       = word_mem[idx][head[idx]];
                            res.src_bucket = BUCKET_W'(idx);
                            head[idx] = (head[idx] + 1) % BUCKET_DEPTH;
                            fill[idx]--;
                            if (fill[idx] == 0)
                            begin
                                flag[idx] = BKT_DRAINED;
                            end
                            start_set = cur_set;
                            found = 1'b1;
                        end
                    end
                end
                if (found)
                begin
                    n_dequeued++;
                end
                else
                begin
                    start_set = start_set % nsets;
                    n_empty++;
                end
            end
            expected_q.push_back(res);
        endfunction

        task report_mismatch(string what);
            if (errors < MAX_PRINTED)
            begin
                $display("[%0t] mismatch: %s", $time, what);
            end
            errors++;
        endtask

        task check_result(logic [STATUS_W-1:0] st, logic [PAYLOAD_W-1:0] w,
                          logic [BUCKET_W-1:0] fb);
            scan_result_t exp;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word status=%0d word=%h bucket=%0d",
                                          st, w, fb));
                return;
            end
            exp = expected_q.pop_front();
            if (st !== exp.status)
            begin
                report_mismatch($sformatf("status got %0d exp %0d", st, exp.status));
            end
            if (w !== exp.word)
            begin
                report_mismatch($sformatf("out_word got %h exp %h", w, exp.word));
            end
            if (fb !== exp.src_bucket)
            begin
                report_mismatch($sformatf("from_bucket got %0d exp %0d", fb, exp.src_bucket));
            end
        endtask
    endclass

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [SET_COUNT_W-1:0] cfg_wr_data = '0;
    logic                   req_valid   = 1'b0;
    logic                   req_stall;
    logic [MODE_W-1:0]      mode        = MODE_ENQ;
    logic [BUCKET_W-1:0]    bucket      = '0;
    logic [PAYLOAD_W-1:0]   payload     = '0;
    logic                   rsp_valid;
    logic                   rsp_stall   = 1'b0;
    logic [STATUS_W-1:0]    status;
    logic [PAYLOAD_W-1:0]   out_word;
    logic [BUCKET_W-1:0]    from_bucket;

    bit                     req_gaps_on = 1'b1;
    bit                     rsp_gaps_on = 1'b1;
    int                     settings_used = 1;
    bucket_scoreboard       sb;

    bucket_queue_set_scan_unit #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .BUCKET_DEPTH (BUCKET_DEPTH),
        .WORD_WIDTH   (WORD_WIDTH)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .mode        (mode),
        .bucket      (bucket),
        .payload     (payload),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .out_word    (out_word),
        .from_bucket (from_bucket)
    );

    always #(CLK_HALF) clk = ~clk;

    task automatic send_request(input logic [MODE_W-1:0] m, input logic [BUCKET_W-1:0] b,
                                input logic [PAYLOAD_W-1:0] p);
        int gap;
        gap = req_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        mode      <= m;
        bucket    <= b;
        payload   <= p;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        sb.note_request(m, b, p);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_set_count(input logic [SET_COUNT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        sb.write_set_count(value);
        settings_used++;
        @(negedge clk);
    endtask

    initial
    begin : result_sink
        int hold;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            hold = rsp_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid)
            begin
                @(posedge clk);
            end
            sb.check_result(status, out_word, from_bucket);
            @(negedge clk);
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        logic [SET_COUNT_W-1:0] phase_cfg [FIXED_PHASES];
        logic [SET_COUNT_W-1:0] cfg;
        int                     nsets;
        int                     enq_pct;
        int                     focus_base;
        bit                     focus;
        logic [MODE_W-1:0]      m;
        logic [BUCKET_W-1:0]    b;
        logic [PAYLOAD_W-1:0]   p;

        sb = new();
        phase_cfg = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd6, 4'd2, 4'd9, 4'd4, 4'd7};
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty scan, extreme buckets and words, rotating start
        send_request(MODE_DEQ, 6'd0, '0);
        send_request(MODE_ENQ, 6'd0, '0);
        send_request(MODE_ENQ, 6'd63, '1);
        repeat (3) send_request(MODE_DEQ, 6'd63, '1);
        wait_drained();

        // start beyond the sets in use, bad bucket, full bucket
        write_set_count(4'd1);
        send_request(MODE_ENQ, 6'd8, 64'hA5A5_5A5A_F00F_0FF0);
        for (int i = 0; i <= BUCKET_DEPTH; i++)
        begin
            send_request(MODE_ENQ, 6'd3, {$urandom, $urandom});
        end
        send_request(MODE_DEQ, 6'd0, '0);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_drained();
            cfg = (ph < FIXED_PHASES) ? phase_cfg[ph] : SET_COUNT_W'($urandom_range(0, 15));
            write_set_count(cfg);
            nsets = (cfg == 0) ? 1 : ((cfg > MAX_SETS) ? MAX_SETS : cfg);
            case ($urandom_range(0, 2))
                0: enq_pct = 30;
                1: enq_pct = 55;
                default: enq_pct = 80;
            endcase
            focus       = ($urandom_range(0, 2) == 0);
            focus_base  = $urandom_range(0, nsets * SET_SIZE - 2);
            req_gaps_on = (ph != 0) && ($urandom_range(0, 3) != 0);
            rsp_gaps_on = (ph != 0) && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                m = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
                if ($urandom_range(0, 9) == 0)
                begin
                    b = BUCKET_W'($urandom_range(0, NUM_BUCKETS - 1));
                end
                else if (focus)
                begin
                    b = BUCKET_W'(focus_base + int'($urandom_range(0, 1)));
                end
                else
                begin
                    b = BUCKET_W'($urandom_range(0, nsets * SET_SIZE - 1));
                end
                case ($urandom_range(0, 15))
                    0: p = '0;
                    1: p = '1;
                    default: p = {$urandom, $urandom};
                endcase
                send_request(m, b, p);
                // halfway through, sometimes hold the sender until all pending results return
                if (k == PHASE_ITEMS / 2 && $urandom_range(0, 1) == 0)
                begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        end
        $display("Ran %0d requests under %0d set-count settings with random idling",
                 sb.requests, settings_used);
        $display("Outcomes: %0d enqueued, %0d full, %0d bad bucket, %0d dequeued, %0d empty",
                 sb.n_enqueued, sb.n_full, sb.n_bad, sb.n_dequeued, sb.n_empty);
        if (sb.errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
